/* rtl/cmf_pkg.sv */
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared constants, types and helpers for the cube map face and uv block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

  localparam int DIR_W       = 16;
  localparam int COORD_W     = 17;
  localparam int COMP_BITS   = 16;
  localparam int FRAC_BITS   = 16;

  localparam int MAG_W       = COMP_BITS;
  localparam int NUM_W       = COMP_BITS + 1;
  localparam int SUM_W       = COMP_BITS + 2;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int STAGES      = FRAC_BITS + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_POS_Y = 3'd1,
    FACE_POS_Z = 3'd2,
    FACE_NEG_X = 3'd3,
    FACE_NEG_Y = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    face_t            face;
    logic             zero;
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    logic [NUM_W-1:0] den;
  } cmf_item_t;

  // sign extend the low COMP_BITS bits of a port value by one bit
  function automatic logic signed [COMP_BITS:0] sext_comp(input logic [DIR_W-1:0] raw);
    logic [COMP_BITS-1:0] low;
    low = raw[COMP_BITS-1:0];
    return $signed({low[COMP_BITS-1], low});
  endfunction

endpackage

`default_nettype wire

/* rtl/cube_map_face_uv_core.sv */
// ----------------------------------------------------------------------------
// cube_map_face_uv_core
// Cube map face selection and fixed point texture coordinates.
//
// An item is a signed direction (dir_x, dir_y, dir_z). It is taken at a
// rising edge with start high and busy low. Each item gives one result:
// face, tex_u, tex_v (unsigned, FRAC_BITS fraction bits, 0 to 1.0) and
// zero_vector, shown for exactly one cycle with done high.
// An item is registered in the classifying front, then in the item queue,
// then in each stage of the divider pipeline, which yields one quotient
// bit of u and v per stage. A new item may be taken every cycle, so busy
// stays low in normal use; it rises only if the queue between front and
// divider fills.
// The receiver cannot stall; results are never held. Synchronous reset
// drops all items in flight and leaves the block ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cube_map_face_uv_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [cmf_pkg::DIR_W-1:0]   dir_x,
  input  logic [cmf_pkg::DIR_W-1:0]   dir_y,
  input  logic [cmf_pkg::DIR_W-1:0]   dir_z,
  output logic                        done,
  output logic [2:0]                  face,
  output logic [cmf_pkg::COORD_W-1:0] tex_u,
  output logic [cmf_pkg::COORD_W-1:0] tex_v,
  output logic                        zero_vector
);
  import cmf_pkg::*;

  cmf_item_t front_item, back_item;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  cmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .busy       (busy),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  cmf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  cmf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (back_valid),
    .item_ready  (back_ready),
    .item        (back_item),
    .done        (done),
    .face        (face),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .zero_vector (zero_vector)
  );

  // the divider never stalls, so the queue never fills
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised although the divider never stalls");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    done && zero_vector |-> face == FACE_NEG_X && tex_u == '0 && tex_v == '0)
    else $error("zero vector result is not face 3 with zero coordinates");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    done |-> tex_u <= (COORD_W'(1) << FRAC_BITS) && tex_v <= (COORD_W'(1) << FRAC_BITS))
    else $error("coordinate above 1.0");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    done |-> face <= FACE_NEG_Z)
    else $error("face code out of range");

endmodule

`default_nettype wire

/* rtl/cmf_front.sv */
// ----------------------------------------------------------------------------
// cmf_front
// Accepts a direction, picks the major axis and face, and forms the
// numerators and denominator of both coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cmf_pkg::DIR_W-1:0] dir_x,
  input  logic [cmf_pkg::DIR_W-1:0] dir_y,
  input  logic [cmf_pkg::DIR_W-1:0] dir_z,
  output logic                      busy,
  output logic                      item_valid,
  input  logic                      item_ready,
  output cmf_pkg::cmf_item_t        item
);
  import cmf_pkg::*;

  logic signed [COMP_BITS:0] sx, sy, sz;
  logic signed [COMP_BITS:0] nx, ny, nz;
  logic [MAG_W-1:0]          ax, ay, az, mag;
  logic signed [SUM_W-1:0]   xs, yns, zs, uc, vc, mag_s, sum_u, sum_v;
  face_t                     face_sel;
  logic                      is_zero;
  logic                      take;
  cmf_item_t                 item_next;

  always_comb begin
    sx = sext_comp(dir_x);
    sy = sext_comp(dir_y);
    sz = sext_comp(dir_z);
    nx = -sx;
    ny = -sy;
    nz = -sz;
    ax = sx[COMP_BITS] ? nx[MAG_W-1:0] : sx[MAG_W-1:0];
    ay = sy[COMP_BITS] ? ny[MAG_W-1:0] : sy[MAG_W-1:0];
    az = sz[COMP_BITS] ? nz[MAG_W-1:0] : sz[MAG_W-1:0];

    // ties go to x, then y
    if (ax >= ay && ax >= az) begin
      mag      = ax;
      face_sel = sx[COMP_BITS] ? FACE_NEG_X : FACE_POS_X;
    end else if (ay >= az) begin
      mag      = ay;
      face_sel = sy[COMP_BITS] ? FACE_NEG_Y : FACE_POS_Y;
    end else begin
      mag      = az;
      face_sel = sz[COMP_BITS] ? FACE_NEG_Z : FACE_POS_Z;
    end
    is_zero = (mag == '0);
    if (is_zero) begin
      face_sel = FACE_NEG_X;
    end

    xs    = {sx[COMP_BITS], sx};
    yns   = -{sy[COMP_BITS], sy};
    zs    = {sz[COMP_BITS], sz};
    mag_s = {2'b00, mag};

    unique case (face_sel)
      FACE_POS_X: begin uc = -zs; vc = yns; end
      FACE_POS_Y: begin uc = xs;  vc = -zs; end
      FACE_POS_Z: begin uc = xs;  vc = yns; end
      FACE_NEG_X: begin uc = zs;  vc = yns; end
      FACE_NEG_Y: begin uc = xs;  vc = -zs; end
      default:    begin uc = -xs; vc = yns; end
    endcase

    sum_u = uc + mag_s;
    sum_v = vc + mag_s;

    item_next.face = face_sel;
    item_next.zero = is_zero;
    if (is_zero) begin
      // zero numerators over a unit denominator give zero coordinates
      item_next.num_u = '0;
      item_next.num_v = '0;
      item_next.den   = NUM_W'(1);
    end else begin
      item_next.num_u = sum_u[NUM_W-1:0];
      item_next.num_v = sum_v[NUM_W-1:0];
      item_next.den   = {mag, 1'b0};
    end
  end

  assign busy = item_valid && !item_ready;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/cmf_queue.sv */
// ----------------------------------------------------------------------------
// cmf_queue
// Small item queue between the classifying front and the divider back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  cmf_pkg::cmf_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cmf_pkg::cmf_item_t pop_item
);
  import cmf_pkg::*;

  cmf_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/cmf_back.sv */
// ----------------------------------------------------------------------------
// cmf_back
// Pipelined restoring divider, one quotient bit per stage, for u and v.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  cmf_pkg::cmf_item_t          item,
  output logic                        done,
  output logic [2:0]                  face,
  output logic [cmf_pkg::COORD_W-1:0] tex_u,
  output logic [cmf_pkg::COORD_W-1:0] tex_v,
  output logic                        zero_vector
);
  import cmf_pkg::*;

  typedef struct packed {
    logic             bit_out;
    logic [NUM_W-1:0] rem;
  } step_t;

  function automatic step_t div_step(input logic [NUM_W:0] trial,
                                     input logic [NUM_W-1:0] den_in);
    step_t      res;
    logic [NUM_W:0] diff;
    diff = trial - {1'b0, den_in};
    res.bit_out = (trial >= {1'b0, den_in});
    res.rem     = res.bit_out ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
    return res;
  endfunction

  logic [STAGES-1:0] vld;
  face_t             fc    [STAGES];
  logic              zr    [STAGES];
  logic [NUM_W-1:0]  den   [STAGES];
  logic [NUM_W-1:0]  rem_u [STAGES];
  logic [NUM_W-1:0]  rem_v [STAGES];
  logic [QUO_W-1:0]  quo_u [STAGES];
  logic [QUO_W-1:0]  quo_v [STAGES];
  step_t             st_u  [STAGES];
  step_t             st_v  [STAGES];

  assign item_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], item_valid};
    end
  end

  // integer bit of the quotient
  assign st_u[0] = div_step({1'b0, item.num_u}, item.den);
  assign st_v[0] = div_step({1'b0, item.num_v}, item.den);

  always_ff @(posedge clk) begin
    fc[0]    <= item.face;
    zr[0]    <= item.zero;
    den[0]   <= item.den;
    rem_u[0] <= st_u[0].rem;
    rem_v[0] <= st_v[0].rem;
    quo_u[0] <= QUO_W'(st_u[0].bit_out);
    quo_v[0] <= QUO_W'(st_v[0].bit_out);
  end

  // fraction bits
  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    assign st_u[k] = div_step({rem_u[k-1], 1'b0}, den[k-1]);
    assign st_v[k] = div_step({rem_v[k-1], 1'b0}, den[k-1]);

    always_ff @(posedge clk) begin
      fc[k]    <= fc[k-1];
      zr[k]    <= zr[k-1];
      den[k]   <= den[k-1];
      rem_u[k] <= st_u[k].rem;
      rem_v[k] <= st_v[k].rem;
      quo_u[k] <= {quo_u[k-1][QUO_W-2:0], st_u[k].bit_out};
      quo_v[k] <= {quo_v[k-1][QUO_W-2:0], st_v[k].bit_out};
    end
  end

  assign done        = vld[STAGES-1];
  assign face        = fc[STAGES-1];
  assign zero_vector = zr[STAGES-1];
  assign tex_u       = COORD_W'(quo_u[STAGES-1]);
  assign tex_v       = COORD_W'(quo_v[STAGES-1]);

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cube_map_face_uv_core. A directed table covers
// the zero vector, the extreme components, the axis tie rules and every
// face. Random directions follow, sent in bursts with random gaps. Each
// accepted item is predicted by the table or a local face/uv predictor,
// and every done strobe is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cmf_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  localparam int DRAIN_CYCLES = 25;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    face_t              face;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic               zero;
  } face_uv_t;

  typedef struct {
    logic [DIR_W-1:0] x;
    logic [DIR_W-1:0] y;
    logic [DIR_W-1:0] z;
    bit               typed;
    face_uv_t         res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [DIR_W-1:0]   dir_x = '0;
  logic [DIR_W-1:0]   dir_y = '0;
  logic [DIR_W-1:0]   dir_z = '0;
  logic               busy;
  logic               done;
  logic [2:0]         face;
  logic [COORD_W-1:0] tex_u;
  logic [COORD_W-1:0] tex_v;
  logic               zero_vector;

  face_uv_t pending_lookups[$];
  dir_row_t stim_rows[$];
  face_uv_t oldest;
  int       mismatches = 0;
  int       result_count = 0;
  int       cycle_count = 0;
  int       burst_left = 1;
  bit       sender_idle = 1'b1;

  cube_map_face_uv_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .done        (done),
    .face        (face),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .zero_vector (zero_vector)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // floor(((c + m) << FRAC_BITS) / 2m)
  function automatic logic [COORD_W-1:0] coord_of(longint c, longint m);
    longint unsigned q;
    q = longint'((c + m) << FRAC_BITS) / longint'(2 * m);
    return q[COORD_W-1:0];
  endfunction

  function automatic face_uv_t predict_face_uv(logic [DIR_W-1:0] rx, logic [DIR_W-1:0] ry,
                                              logic [DIR_W-1:0] rz);
    longint   sx, sy, sz, ax, ay, az, mag, dom, uc, vc;
    int       axis;
    face_uv_t r;
    sx = longint'($signed(rx));
    sy = longint'($signed(ry));
    sz = longint'($signed(rz));
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    mag = ax;
    dom = sx;
    axis = 0;
    if (mag < ay) begin
      mag = ay;
      dom = sy;
      axis = 1;
    end
    if (mag < az) begin
      mag = az;
      dom = sz;
      axis = 2;
    end
    if (mag == 0) begin
      r.face = FACE_NEG_X;
      r.u = '0;
      r.v = '0;
      r.zero = 1'b1;
      return r;
    end
    case (axis)
      0: r.face = (dom > 0) ? FACE_POS_X : FACE_NEG_X;
      1: r.face = (dom > 0) ? FACE_POS_Y : FACE_NEG_Y;
      default: r.face = (dom > 0) ? FACE_POS_Z : FACE_NEG_Z;
    endcase
    // y is flipped before the face table
    case (r.face)
      FACE_POS_X: begin uc = -sz; vc = -sy; end
      FACE_POS_Y: begin uc = sx;  vc = -sz; end
      FACE_POS_Z: begin uc = sx;  vc = -sy; end
      FACE_NEG_X: begin uc = sz;  vc = -sy; end
      FACE_NEG_Y: begin uc = sx;  vc = -sz; end
      default:    begin uc = -sx; vc = -sy; end
    endcase
    r.u = coord_of(uc, mag);
    r.v = coord_of(vc, mag);
    r.zero = 1'b0;
    return r;
  endfunction

  function automatic void add_row(int x, int y, int z, bit typed, face_t f,
                                  int u, int v, bit zero);
    dir_row_t row;
    row.x = x[DIR_W-1:0];
    row.y = y[DIR_W-1:0];
    row.z = z[DIR_W-1:0];
    row.typed = typed;
    row.res.face = f;
    row.res.u = u[COORD_W-1:0];
    row.res.v = v[COORD_W-1:0];
    row.res.zero = zero;
    stim_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("result %0d: %s got %0d expected %0d", result_count, what, got, want);
  endtask

  task automatic send_dir(logic [DIR_W-1:0] x, logic [DIR_W-1:0] y, logic [DIR_W-1:0] z,
                          face_uv_t res);
    int gap;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    start <= 1'b1;
    sender_idle = 1'b0;
    do @(posedge clk); while (busy);
    pending_lookups.push_back(res);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        sender_idle = 1'b1;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
  endtask

  task automatic drain_results();
    if (!sender_idle) begin
      start <= 1'b0;
      sender_idle = 1'b1;
    end
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic pick_dir(output logic [DIR_W-1:0] x, output logic [DIR_W-1:0] y,
                          output logic [DIR_W-1:0] z);
    int c[3];
    int kind, mag, sel;
    kind = $urandom_range(0, 99);
    sel = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) c[i] = 0;
    if (kind < 35) begin
      for (int i = 0; i < 3; i++) c[i] = $urandom;
    end else if (kind < 55) begin
      for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 8) - 4;
    end else if (kind < 70) begin
      // equal magnitudes on two or three axes
      mag = $urandom_range(1, 32767);
      for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 1) ? mag : -mag;
      if ($urandom_range(0, 1)) c[sel] = $urandom_range(0, mag) * ($urandom_range(0, 1) ? 1 : -1);
    end else if (kind < 80) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 5))
          0: c[i] = -32768;
          1: c[i] = -32767;
          2: c[i] = -1;
          3: c[i] = 0;
          4: c[i] = 1;
          default: c[i] = 32767;
        endcase
      end
    end else if (kind < 95) begin
      mag = $urandom_range(1, 32768);
      for (int i = 0; i < 3; i++) begin
        c[i] = $urandom_range(0, 2 * mag) - mag;
        if (c[i] > 32767) c[i] = 32767;
      end
      c[sel] = (mag == 32768 || $urandom_range(0, 1)) ? -mag : mag;
    end else begin
      if ($urandom_range(0, 1)) c[sel] = $urandom;
    end
    x = c[0][DIR_W-1:0];
    y = c[1][DIR_W-1:0];
    z = c[2][DIR_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected item, face", face, 0);
      end else begin
        oldest = pending_lookups.pop_front();
        if (face != oldest.face) report_mismatch("face", face, oldest.face);
        if (tex_u != oldest.u) report_mismatch("tex_u", tex_u, oldest.u);
        if (tex_v != oldest.v) report_mismatch("tex_v", tex_v, oldest.v);
        if (zero_vector != oldest.zero) report_mismatch("zero_vector", zero_vector, oldest.zero);
      end
      result_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [DIR_W-1:0] rx, ry, rz;
    add_row(0, 0, 0, 1, FACE_NEG_X, 0, 0, 1);
    add_row(32767, 0, 0, 1, FACE_POS_X, 32768, 32768, 0);
    add_row(-32768, 0, 0, 1, FACE_NEG_X, 32768, 32768, 0);
    add_row(0, 32767, 0, 1, FACE_POS_Y, 32768, 32768, 0);
    add_row(0, -32768, 0, 1, FACE_NEG_Y, 32768, 32768, 0);
    add_row(0, 0, 32767, 1, FACE_POS_Z, 32768, 32768, 0);
    add_row(0, 0, -32768, 1, FACE_NEG_Z, 32768, 32768, 0);
    add_row(32767, 32767, 32767, 1, FACE_POS_X, 0, 0, 0);
    add_row(-32768, -32768, -32768, 1, FACE_NEG_X, 0, 65536, 0);
    add_row(1, 0, 0, 1, FACE_POS_X, 32768, 32768, 0);
    add_row(-1, -1, -1, 1, FACE_NEG_X, 0, 65536, 0);
    add_row(32767, -32768, 0, 1, FACE_NEG_Y, 65535, 32768, 0);
    add_row(0, 5, -5, 0, FACE_NEG_X, 0, 0, 0);
    add_row(3, -3, 0, 0, FACE_NEG_X, 0, 0, 0);
    add_row(-7, 2, 7, 0, FACE_NEG_X, 0, 0, 0);
    add_row(100, -50, 25, 0, FACE_NEG_X, 0, 0, 0);
    add_row(-100, 30, -60, 0, FACE_NEG_X, 0, 0, 0);
    add_row(20, -90, 40, 0, FACE_NEG_X, 0, 0, 0);
    add_row(-5, -60, 55, 0, FACE_NEG_X, 0, 0, 0);
    add_row(12, 7, -31, 0, FACE_NEG_X, 0, 0, 0);
    add_row(-3, 1, -2, 0, FACE_NEG_X, 0, 0, 0);
    add_row(32767, -32767, -32768, 0, FACE_NEG_X, 0, 0, 0);
    add_row(-32768, 32767, 1, 0, FACE_NEG_X, 0, 0, 0);
    add_row(0, 0, -1, 0, FACE_NEG_X, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      send_dir(stim_rows[i].x, stim_rows[i].y, stim_rows[i].z,
               stim_rows[i].typed ? stim_rows[i].res
                                  : predict_face_uv(stim_rows[i].x, stim_rows[i].y,
                                                    stim_rows[i].z));
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick_dir(rx, ry, rz);
      send_dir(rx, ry, rz, predict_face_uv(rx, ry, rz));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cmf_pkg.sv
rtl/cmf_front.sv
rtl/cmf_queue.sv
rtl/cmf_back.sv
rtl/cube_map_face_uv_core.sv
tb/tb.sv
